// ===== hdl/shash_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package shash_pkg;

   localparam int unsigned HASH_W      = 32;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 3;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [HASH_W-1:0] SEED_DJB2 = 32'd5381;
   localparam logic [HASH_W-1:0] SEED_FNV  = 32'd2166136261;
   localparam logic [HASH_W-1:0] PRIME_FNV = 32'd16777619;
   localparam logic [HASH_W-1:0] MIX_MULT  = 32'h3243f6a9;

   typedef enum logic [2:0] {
      ALGO_SUM  = 3'd0,
      ALGO_DJB2 = 3'd1,
      ALGO_SDBM = 3'd2,
      ALGO_OAAT = 3'd3,
      ALGO_FNV  = 3'd4
   } algo_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ALGORITHM  = 1'b0,
      CSR_MIX_ENABLE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              has_byte;
      logic              last;
   } entry_type;

   typedef struct packed {
      algo_type algo;
      logic     mix_enable;
   } fin_ctl_type;

   // unused codes fall back to the byte sum
   function automatic algo_type algo_decode(input logic [2:0] value);
      algo_type code;
      unique case (value)
         3'd1:    code = ALGO_DJB2;
         3'd2:    code = ALGO_SDBM;
         3'd3:    code = ALGO_OAAT;
         3'd4:    code = ALGO_FNV;
         default: code = ALGO_SUM;
      endcase
      return code;
   endfunction

   function automatic logic [HASH_W-1:0] seed_of(input algo_type code);
      logic [HASH_W-1:0] seed;
      unique case (code)
         ALGO_DJB2: seed = SEED_DJB2;
         ALGO_FNV:  seed = SEED_FNV;
         default:   seed = '0;
      endcase
      return seed;
   endfunction

   function automatic logic [HASH_W-1:0] fold_byte(input algo_type          code,
                                                    input logic [HASH_W-1:0] h,
                                                    input logic [BYTE_W-1:0] c);
      logic [HASH_W-1:0] c_ext;
      logic [HASH_W-1:0] t;
      logic [HASH_W-1:0] result;
      c_ext = {{(HASH_W-BYTE_W){1'b0}}, c};
      t     = '0;
      unique case (code)
         ALGO_DJB2: result = (h << 5) + h + c_ext;
         ALGO_SDBM: result = c_ext + (h << 6) + (h << 16) - h;
         ALGO_OAAT: begin
            t      = h + c_ext;
            t      = t + (t << 10);
            result = t ^ (t >> 6);
         end
         ALGO_FNV:  result = (h * PRIME_FNV) ^ c_ext;
         default:   result = h + c_ext;
      endcase
      return result;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/string_hash_engine.sv =====
// Throughput: one byte per cycle while req_stall is low; the running hash updates in a
// loop through a single register, and the finish runs in a four-stage pipe (mixer
// multiply has its own stage).
// Reset (synchronous): algorithm djb2, mixer enabled, running hash 5381,
// queue and finishing pipe empty.
`timescale 1ns / 1ps
`default_nettype none
module string_hash_engine
   import shash_pkg::*;
#(
   parameter int unsigned QueueDepth = QUEUE_DEPTH
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [BYTE_W-1:0]      req_data_byte,
   input  wire logic                   req_has_byte,
   input  wire logic                   req_last,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [HASH_W-1:0]           rsp_hash_value,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic              q_full, q_push, q_pop, q_valid;
   entry_type         q_entry, q_head;
   logic              fin_ready, fin_valid;
   logic [HASH_W-1:0] fin_hash;
   fin_ctl_type       fin_ctl;

   shash_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_has_byte  (req_has_byte),
      .req_last      (req_last),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   shash_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (q_head)
   );

   shash_fold u_fold (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_valid          (q_valid),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .fin_ready        (fin_ready),
      .fin_valid        (fin_valid),
      .fin_hash         (fin_hash),
      .fin_ctl          (fin_ctl)
   );

   shash_finish u_finish (
      .clock          (clock),
      .reset          (reset),
      .fin_valid      (fin_valid),
      .fin_hash       (fin_hash),
      .fin_ctl        (fin_ctl),
      .fin_ready      (fin_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule
`default_nettype wire

// ===== hdl/shash_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module shash_front
   import shash_pkg::*;
(
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [BYTE_W-1:0] req_data_byte,
   input  wire logic              req_has_byte,
   input  wire logic              req_last,
   input  wire logic              q_full,
   output logic                   q_push,
   output entry_type              q_entry
);

   logic accept;

   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;

   // drop idle transactions: no byte and no end of string
   assign q_push = accept & (req_has_byte | req_last);

   always_comb begin
      q_entry.data_byte = req_data_byte;
      q_entry.has_byte  = req_has_byte;
      q_entry.last      = req_last;
   end

endmodule
`default_nettype wire

// ===== hdl/shash_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module shash_queue
   import shash_pkg::*;
#(
   parameter int unsigned Depth = QUEUE_DEPTH
)
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output logic           valid,
   output entry_type      head
);

   localparam int unsigned PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CNT_W = $clog2(Depth + 1);

   entry_type          store_ff [Depth];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_W'(Depth));
   assign valid = (count_ff != '0);
   assign head  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/shash_fold.sv =====
`timescale 1ns / 1ps
`default_nettype none
module shash_fold
   import shash_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   input  wire logic                   q_valid,
   input  wire entry_type              q_head,
   output logic                        q_pop,
   input  wire logic                   fin_ready,
   output logic                        fin_valid,
   output logic [HASH_W-1:0]           fin_hash,
   output fin_ctl_type                 fin_ctl
);

   algo_type          algo_ff, algo_in;
   logic              mix_ff, mix_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [HASH_W-1:0] folded;

   assign folded = q_head.has_byte ? fold_byte(algo_ff, hash_ff, q_head.data_byte) : hash_ff;

   // a string end waits until the finishing pipe has room
   assign q_pop     = q_valid & (~q_head.last | fin_ready);
   assign fin_valid = q_pop & q_head.last;
   assign fin_hash  = folded;

   always_comb begin
      fin_ctl.algo       = algo_ff;
      fin_ctl.mix_enable = mix_ff;
   end

   always_comb begin
      algo_in = algo_ff;
      mix_in  = mix_ff;
      hash_in = hash_ff;
      if (q_pop) begin
         hash_in = q_head.last ? seed_of(algo_ff) : folded;
      end
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_ALGORITHM: begin
               algo_in = algo_decode(csr_write_data);
               hash_in = seed_of(algo_decode(csr_write_data));
            end
            CSR_MIX_ENABLE: mix_in = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         algo_ff <= ALGO_DJB2;
         mix_ff  <= 1'b1;
         hash_ff <= SEED_DJB2;
      end else begin
         algo_ff <= algo_in;
         mix_ff  <= mix_in;
         hash_ff <= hash_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/shash_finish.sv =====
`timescale 1ns / 1ps
`default_nettype none
module shash_finish
   import shash_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fin_valid,
   input  wire logic [HASH_W-1:0] fin_hash,
   input  wire fin_ctl_type       fin_ctl,
   output logic                   fin_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [HASH_W-1:0]      rsp_hash_value
);

   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic [HASH_W-1:0] s1_hash_ff, s2_hash_ff, s3_hash_ff;
   fin_ctl_type       s1_ctl_ff;
   logic              s2_mix_ff, s3_mix_ff;
   logic              out_free, s3_free, s2_free, s1_free;
   logic [HASH_W-1:0] s2_hash_in, s3_hash_in, out_hash_in;
   logic [HASH_W-1:0] t;
   logic              s2_mix_in;

   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign s3_free   = ~s3_valid_ff | out_free;
   assign s2_free   = ~s2_valid_ff | s3_free;
   assign s1_free   = ~s1_valid_ff | s2_free;
   assign fin_ready = s1_free;

   assign rsp_valid = out_valid_ff;

   // one-at-a-time finalization, or the first xor-shift of the djb2 mixer
   always_comb begin
      t          = s1_hash_ff;
      s2_mix_in  = (s1_ctl_ff.algo == ALGO_DJB2) & s1_ctl_ff.mix_enable;
      s2_hash_in = s1_hash_ff;
      if (s1_ctl_ff.algo == ALGO_OAAT) begin
         t          = t + (t << 3);
         t          = t ^ (t >> 11);
         s2_hash_in = t + (t << 15);
      end else if (s2_mix_in) begin
         s2_hash_in = s1_hash_ff ^ (s1_hash_ff >> 16);
      end
   end

   assign s3_hash_in  = s2_mix_ff ? s2_hash_ff * MIX_MULT : s2_hash_ff;
   assign out_hash_in = s3_mix_ff ? s3_hash_ff ^ (s3_hash_ff >> 16) : s3_hash_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= fin_valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_free) begin
            out_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_hash_ff <= fin_hash;
         s1_ctl_ff  <= fin_ctl;
      end
      if (s2_free) begin
         s2_hash_ff <= s2_hash_in;
         s2_mix_ff  <= s2_mix_in;
      end
      if (s3_free) begin
         s3_hash_ff <= s3_hash_in;
         s3_mix_ff  <= s2_mix_ff;
      end
      if (out_free) begin
         rsp_hash_value <= out_hash_in;
      end
   end

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import shash_pkg::*;

   localparam int unsigned QUIET_LIMIT   = 2000;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned HOLD_CYCLES   = 120;
   localparam int unsigned PHASE_COUNT   = 12;
   localparam int unsigned PHASE_ITEMS   = 120;
   localparam int unsigned REPORT_CAP    = 100;

   // codes above FNV-1 are unassigned and fold as the byte sum
   localparam logic [2:0] ALGO_SPARE_LO = 3'd5;
   localparam logic [2:0] ALGO_SPARE_HI = 3'd7;

   localparam logic [HASH_W-1:0] HASH_START_DJB2 = 32'd5381;
   localparam logic [HASH_W-1:0] HASH_START_FNV  = 32'd2166136261;
   localparam logic [HASH_W-1:0] FNV_MULT        = 32'd16777619;
   localparam logic [HASH_W-1:0] MIXER_MULT      = 32'h3243f6a9;
   localparam logic [HASH_W-1:0] DJB2_MULT       = 32'd33;
   localparam logic [HASH_W-1:0] SDBM_MULT       = 32'd65599;

   class hash_scoreboard;
      logic [2:0]        algo_reg;
      logic              mix_reg;
      logic [HASH_W-1:0] running;
      logic [HASH_W-1:0] pending_hashes[$];
      int                error_count;

      function new();
         error_count = 0;
         algo_reg    = ALGO_DJB2;
         mix_reg     = 1'b1;
         running     = start_value(active_algo());
      endfunction

      function algo_type active_algo();
         if (algo_reg > ALGO_FNV)
            return ALGO_SUM;
         return algo_type'(algo_reg);
      endfunction

      function logic [HASH_W-1:0] start_value(algo_type code);
         case (code)
            ALGO_DJB2: return HASH_START_DJB2;
            ALGO_FNV:  return HASH_START_FNV;
            default:   return '0;
         endcase
      endfunction

      function logic [HASH_W-1:0] fold_char(algo_type code, logic [HASH_W-1:0] h,
                                            logic [BYTE_W-1:0] c);
         logic [HASH_W-1:0] wide;
         logic [HASH_W-1:0] t;
         wide = '0;
         wide[BYTE_W-1:0] = c;
         case (code)
            ALGO_DJB2: return h * DJB2_MULT + wide;
            ALGO_SDBM: return h * SDBM_MULT + wide;
            ALGO_OAAT: begin
               t = h + wide;
               t = t + (t << 10);
               return t ^ (t >> 6);
            end
            ALGO_FNV:  return (h * FNV_MULT) ^ wide;
            default:   return h + wide;
         endcase
      endfunction

      function logic [HASH_W-1:0] finish_hash(algo_type code, logic [HASH_W-1:0] h);
         if (code == ALGO_OAAT) begin
            h = h + (h << 3);
            h = h ^ (h >> 11);
            h = h + (h << 15);
         end else if (code == ALGO_DJB2 && mix_reg) begin
            h = h ^ (h >> 16);
            h = h * MIXER_MULT;
            h = h ^ (h >> 16);
         end
         return h;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_ALGORITHM: begin
               algo_reg = data;
               running  = start_value(active_algo());
            end
            CSR_MIX_ENABLE: mix_reg = data[0];
            default: ;
         endcase
      endfunction

      function void note_request(logic [BYTE_W-1:0] value, logic has, logic closes);
         algo_type code;
         code = active_algo();
         if (has)
            running = fold_char(code, running, value);
         if (closes) begin
            pending_hashes.push_back(finish_hash(code, running));
            running = start_value(code);
         end
      endfunction

      function int pending_count();
         return pending_hashes.size();
      endfunction

      task report(string what);
         if (error_count < REPORT_CAP)
            $display("%0t mismatch: %s", $realtime, what);
         error_count++;
      endtask

      task check_response(logic [HASH_W-1:0] got);
         logic [HASH_W-1:0] want;
         if (pending_hashes.size() == 0) begin
            report($sformatf("hash_value %h with no string closed", got));
         end else begin
            want = pending_hashes.pop_front();
            if (got !== want)
               report($sformatf("hash_value %h, predicted %h", got, want));
         end
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_data_byte = '0;
   logic                   req_has_byte = 1'b0;
   logic                   req_last = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [HASH_W-1:0]      rsp_hash_value;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   bit             idle_on = 1'b1;
   bit             pressure_req = 1'b0;
   int unsigned    sent_items = 0;
   int unsigned    quiet_cycles = 0;
   hash_scoreboard hash_sb = new();

   string_hash_engine dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
         hash_sb.check_response(rsp_hash_value);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)
          || csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stall bursts, plus one long hold-off to back up the block
   always begin
      @(negedge clock);
      if (pressure_req) begin
         rsp_stall <= 1'b1;
         repeat (HOLD_CYCLES) @(negedge clock);
         pressure_req = 1'b0;
         rsp_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 13)) @(negedge clock);
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_item(logic [BYTE_W-1:0] value, logic has, logic closes);
      @(negedge clock);
      if (idle_on && !pressure_req && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      req_has_byte  <= has;
      req_last      <= closes;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      hash_sb.note_request(value, has, closes);
      if (has || closes)
         sent_items++;
   endtask

   // drop valid, let every closed string come out, then let the pipe settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (hash_sb.pending_count() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      hash_sb.write_reg(idx, data);
   endtask

   task automatic send_string(int unsigned len, bit closed);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0)
            send_item(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_item(BYTE_W'($urandom_range(0, 255)), 1'b1, closed && i == len - 1);
      end
      if (len == 0 && closed)
         send_item(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   initial begin
      logic [2:0]            sweep[5];
      logic [2:0]            phase_algos[8];
      logic [2:0]            algo_value;
      logic [CSR_DATA_W-1:0] mix_data;
      int unsigned           quota;
      int unsigned           pick;

      sweep       = '{ALGO_SUM, ALGO_SDBM, ALGO_OAAT, ALGO_FNV, ALGO_SPARE_HI};
      phase_algos = '{ALGO_SUM, ALGO_FNV, ALGO_SPARE_HI, ALGO_DJB2,
                      ALGO_OAAT, ALGO_SDBM, ALGO_SPARE_LO, ALGO_DJB2};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: djb2 with the mixer; empty string, idle item, byte extremes
      send_item(8'h5a, 1'b0, 1'b1);
      send_item(8'ha5, 1'b0, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hff, 1'b1, 1'b1);

      foreach (sweep[k]) begin
         wait_idle();
         csr_write(CSR_ALGORITHM, sweep[k]);
         send_item(8'hff, 1'b1, 1'b0);
         send_item(8'h01, 1'b1, 1'b1);
         send_item(8'h00, 1'b0, 1'b1);
      end

      wait_idle();
      csr_write(CSR_MIX_ENABLE, 3'b000);
      csr_write(CSR_ALGORITHM, ALGO_DJB2);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h7f, 1'b1, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);
      // leave a string open; the next algorithm write drops it
      send_item(8'h41, 1'b1, 1'b0);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_idle();
         if (p >= PHASE_COUNT - 3)
            idle_on = 1'b0;
         algo_value = (p < 8) ? phase_algos[p] : 3'($urandom_range(0, 7));
         mix_data   = CSR_DATA_W'($urandom_range(0, 7));
         if (p == 3)
            mix_data[0] = 1'b1;
         if (p == 7)
            mix_data[0] = 1'b0;
         if ($urandom_range(0, 1)) begin
            csr_write(CSR_MIX_ENABLE, mix_data);
            csr_write(CSR_ALGORITHM, algo_value);
         end else begin
            csr_write(CSR_ALGORITHM, algo_value);
            csr_write(CSR_MIX_ENABLE, mix_data);
         end
         if (p == 4)
            pressure_req = 1'b1;
         quota = sent_items + PHASE_ITEMS;
         while (sent_items < quota) begin
            pick = $urandom_range(0, 99);
            if (pressure_req)
               send_string($urandom_range(1, 2), 1'b1);
            else if (pick < 6)
               send_string(0, 1'b1);
            else if (pick < 12)
               send_string($urandom_range(1, 5), 1'b0);
            else if (pick < 20)
               send_string($urandom_range(13, 40), 1'b1);
            else
               send_string($urandom_range(1, 12), 1'b1);
         end
      end

      wait_idle();
      if (hash_sb.error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/shash_pkg.sv
hdl/shash_front.sv
hdl/shash_queue.sv
hdl/shash_fold.sv
hdl/shash_finish.sv
hdl/string_hash_engine.sv
dv/testbench.sv
